### src/frame_delta_packetizer_defines.svh
// Assertion macros for the frame delta packetizer RTL, used by fdp_back.
// Depends on a clock named clock and an active-high reset named reset.
`ifndef FRAME_DELTA_PACKETIZER_DEFINES_SVH
`define FRAME_DELTA_PACKETIZER_DEFINES_SVH

// check a property on every clock edge outside reset
`define FDP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property on every clock edge, reset included
`define FDP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/fdp_pkg.sv
// Package for the frame delta packetizer: constants, command type, report size tables.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package fdp_pkg;
   localparam int FRAME_BYTES_DEF = 1024;
   localparam int MAX_PAYLOAD     = 128;
   localparam int CLEAN_LIMIT     = 4;
   localparam int HEADER_BYTES    = 4;
   localparam int IMG_WORDS       = 17;
   localparam int ADDR_W          = 16;
   localparam logic [7:0] SHADOW_RESET = 8'h55;
   localparam logic [10:0] FRAME_SIZE_RESET = 11'd1024;
   localparam logic [7:0]  REPORT_ID_RESET  = 8'd8;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   localparam logic [0:0] REG_FRAME_SIZE = 1'b0;
   localparam logic [0:0] REG_REPORT_ID  = 1'b1;

   typedef struct packed {
      logic              op;
      logic [7:0]        data;
      logic [ADDR_W-1:0] addr;
   } cmd_type;

   function automatic logic [2:0] size_index(input logic [7:0] len);
      logic [8:0] total;
      total = {1'b0, len} + 9'd4;
      if (total <= 9'd8) begin
         size_index = 3'd0;
      end else if (total <= 9'd12) begin
         size_index = 3'd1;
      end else if (total <= 9'd20) begin
         size_index = 3'd2;
      end else if (total <= 9'd36) begin
         size_index = 3'd3;
      end else if (total <= 9'd68) begin
         size_index = 3'd4;
      end else begin
         size_index = 3'd5;
      end
   endfunction

   function automatic logic [4:0] size_words(input logic [2:0] idx);
      case (idx)
         3'd0: size_words = 5'd1;
         3'd1: size_words = 5'd2;
         3'd2: size_words = 5'd3;
         3'd3: size_words = 5'd5;
         3'd4: size_words = 5'd9;
         default: size_words = 5'd17;
      endcase
   endfunction
endpackage

### src/fdp_front.sv
// Front of the frame delta packetizer: shadow frame, dirty test, gap tracking.
// Turns each frame byte into append and flush commands; uses fdp_pkg.
`timescale 1ns / 1ps
module fdp_front
   import fdp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_byte,
   input  logic [10:0] frame_size,
   output logic        cmd_push,
   output cmd_type     cmd_in,
   input  logic        cmd_full
);
   localparam int PW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int EW = ((PW > 11) ? PW : 11) + 1;
   localparam logic [1:0] F_CLEAR = 2'd0;
   localparam logic [1:0] F_IDLE  = 2'd1;
   localparam logic [1:0] F_LOOK  = 2'd2;
   localparam logic [1:0] F_PUSH  = 2'd3;

   logic [7:0]    shadow [FRAME_BYTES];
   logic [7:0]    shadow_rd_ff;
   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] clr_ff, clr_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [2:0]    clean_ff, clean_in;
   logic [2:0]    clean_nx_ff, clean_nx_in;
   logic [2:0]    gap_ff, gap_in;
   logic          byte_pend_ff, byte_pend_in;
   logic          flush_pend_ff, flush_pend_in;
   logic          end_pend_ff, end_pend_in;
   logic [7:0]    v_ff, v_in;
   logic [7:0]    hist_ff [4];
   logic          hist_shift;
   logic          sh_we;
   logic [PW-1:0] sh_waddr;
   logic [7:0]    sh_wdata;
   logic [EW-1:0] eff;
   logic          dirty, last;
   logic [1:0]    hidx;

   always_ff @(posedge clock) begin
      if (sh_we) begin
         shadow[sh_waddr] <= sh_wdata;
      end
      shadow_rd_ff <= shadow[pos_ff];
   end

   always_comb begin
      if (frame_size == 11'd0) begin
         eff = EW'(1);
      end else if (EW'(frame_size) > EW'(FRAME_BYTES)) begin
         eff = EW'(FRAME_BYTES);
      end else begin
         eff = EW'(frame_size);
      end
      last  = (EW'(pos_ff) + EW'(1)) >= eff;
      dirty = shadow_rd_ff != v_ff;
      hidx  = 2'(gap_ff - 3'd1);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pos_in        = pos_ff;
      clean_in      = clean_ff;
      clean_nx_in   = clean_nx_ff;
      gap_in        = gap_ff;
      byte_pend_in  = byte_pend_ff;
      flush_pend_in = flush_pend_ff;
      end_pend_in   = end_pend_ff;
      v_in          = v_ff;
      hist_shift    = 1'b0;
      sh_we         = 1'b0;
      sh_waddr      = pos_ff;
      sh_wdata      = v_ff;
      cmd_push      = 1'b0;
      cmd_in        = '{op: OP_APPEND, data: v_ff, addr: ADDR_W'(pos_ff)};
      req_ready     = (state_ff == F_IDLE);
      case (state_ff)
         F_CLEAR: begin
            sh_we    = 1'b1;
            sh_waddr = clr_ff;
            sh_wdata = SHADOW_RESET;
            clr_in   = clr_ff + PW'(1);
            if (clr_ff == PW'(FRAME_BYTES - 1)) begin
               state_in = F_IDLE;
            end
         end
         F_IDLE: begin
            if (req_valid) begin
               v_in     = req_pixel_byte;
               state_in = F_LOOK;
            end
         end
         F_LOOK: begin
            end_pend_in = last;
            if (dirty) begin
               sh_we         = 1'b1;
               gap_in        = (clean_ff <= 3'(CLEAN_LIMIT) && EW'(clean_ff) <= EW'(pos_ff))
                               ? clean_ff : 3'd0;
               byte_pend_in  = 1'b1;
               flush_pend_in = 1'b0;
               clean_nx_in   = 3'd0;
            end else begin
               gap_in        = 3'd0;
               byte_pend_in  = 1'b0;
               flush_pend_in = (clean_ff == 3'(CLEAN_LIMIT));
               clean_nx_in   = (clean_ff <= 3'(CLEAN_LIMIT)) ? clean_ff + 3'd1 : clean_ff;
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (gap_ff != 3'd0) begin
               if (!cmd_full) begin
                  cmd_push = 1'b1;
                  cmd_in   = '{op: OP_APPEND, data: hist_ff[hidx],
                               addr: ADDR_W'(pos_ff - PW'(gap_ff))};
                  gap_in   = gap_ff - 3'd1;
               end
            end else if (byte_pend_ff) begin
               if (!cmd_full) begin
                  cmd_push     = 1'b1;
                  byte_pend_in = 1'b0;
               end
            end else if (flush_pend_ff || end_pend_ff) begin
               if (!cmd_full) begin
                  cmd_push = 1'b1;
                  cmd_in.op = OP_FLUSH;
                  if (flush_pend_ff) begin
                     flush_pend_in = 1'b0;
                  end else begin
                     end_pend_in = 1'b0;
                  end
               end
            end else begin
               hist_shift = 1'b1;
               if (last) begin
                  pos_in   = '0;
                  clean_in = 3'd0;
               end else begin
                  pos_in   = pos_ff + PW'(1);
                  clean_in = clean_nx_ff;
               end
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_CLEAR;
         clr_ff        <= '0;
         pos_ff        <= '0;
         clean_ff      <= 3'd0;
         gap_ff        <= 3'd0;
         byte_pend_ff  <= 1'b0;
         flush_pend_ff <= 1'b0;
         end_pend_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pos_ff        <= pos_in;
         clean_ff      <= clean_in;
         gap_ff        <= gap_in;
         byte_pend_ff  <= byte_pend_in;
         flush_pend_ff <= flush_pend_in;
         end_pend_ff   <= end_pend_in;
      end
      clean_nx_ff <= clean_nx_in;
      v_ff        <= v_in;
      if (hist_shift) begin
         hist_ff[0] <= v_ff;
         hist_ff[1] <= hist_ff[0];
         hist_ff[2] <= hist_ff[1];
         hist_ff[3] <= hist_ff[2];
      end
   end
endmodule

### src/fdp_cmd_fifo.sv
// Command queue between front and back of the frame delta packetizer.
// Four-entry FIFO of cmd_type; uses fdp_pkg.
`timescale 1ns / 1ps
module fdp_cmd_fifo
   import fdp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type cmd_in,
   output logic    full,
   input  logic    pop,
   output cmd_type cmd_out,
   output logic    empty
);
   cmd_type    mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full    = cnt_ff == 3'd4;
   assign empty   = cnt_ff == 3'd0;
   assign cmd_out = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wp_ff] <= cmd_in;
      end
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (push && !full) begin
            wp_ff <= wp_ff + 2'd1;
         end
         if (pop && !empty) begin
            rp_ff <= rp_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + 3'(push && !full) - 3'(pop && !empty);
      end
   end
endmodule

### src/fdp_back.sv
// Back of the frame delta packetizer: payload buffer and report word output.
// Executes queued commands; uses fdp_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "frame_delta_packetizer_defines.svh"
module fdp_back
   import fdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_empty,
   input  cmd_type     cmd_out,
   output logic        cmd_pop,
   input  logic [7:0]  report_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_report_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_report_last
);
   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_RD   = 2'd1;
   localparam logic [1:0] B_WR   = 2'd2;

   logic [63:0]       img [IMG_WORDS];
   logic [63:0]       img_rd_ff;
   logic [1:0]        state_ff, state_in;
   logic [7:0]        len_ff, len_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [4:0]        w_ff, w_in;
   logic              out_v_ff, out_v_in;
   logic [63:0]       word_ff, word_in;
   logic [3:0]        nb_ff, nb_in;
   logic              last_ff, last_in;
   logic              we;
   logic [7:0]        wpos;
   logic [2:0]        idx;
   logic [4:0]        nwords;
   logic [8:0]        img_len;
   logic [7:0]        hdr [4];

   assign wpos    = len_ff + 8'd4;
   assign idx     = size_index(len_ff);
   assign nwords  = size_words(idx);
   assign img_len = {1'b0, len_ff} + 9'd4;
   assign hdr[0]  = report_id + {5'd0, idx};
   assign hdr[1]  = start_ff[7:0];
   assign hdr[2]  = start_ff[15:8];
   assign hdr[3]  = len_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         if (we && wpos[2:0] == 3'(i)) begin
            img[wpos[7:3]][i*8 +: 8] <= cmd_out.data;
         end
      end
      img_rd_ff <= img[w_ff];
   end

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      start_in = start_ff;
      w_in     = w_ff;
      out_v_in = out_v_ff && !rsp_ready;
      word_in  = word_ff;
      nb_in    = nb_ff;
      last_in  = last_ff;
      we       = 1'b0;
      cmd_pop  = 1'b0;
      case (state_ff)
         B_IDLE: begin
            w_in = 5'd0;
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_out.op == OP_APPEND) begin
                  we     = 1'b1;
                  len_in = len_ff + 8'd1;
                  if (len_ff == 8'd0) begin
                     start_in = cmd_out.addr;
                  end
                  if (len_ff == 8'(MAX_PAYLOAD - 1)) begin
                     state_in = B_RD;
                  end
               end else if (len_ff != 8'd0) begin
                  state_in = B_RD;
               end
            end
         end
         B_RD: state_in = B_WR;
         B_WR: begin
            if (!out_v_ff || rsp_ready) begin
               out_v_in = 1'b1;
               for (int i = 0; i < 8; i++) begin
                  if (w_ff == 5'd0 && i < HEADER_BYTES) begin
                     word_in[i*8 +: 8] = hdr[i];
                  end else if ({1'b0, w_ff, 3'(i)} < img_len) begin
                     word_in[i*8 +: 8] = img_rd_ff[i*8 +: 8];
                  end else begin
                     word_in[i*8 +: 8] = 8'd0;
                  end
               end
               last_in = (w_ff == nwords - 5'd1);
               nb_in   = (last_in && idx != 3'd0) ? 4'd4 : 4'd8;
               if (last_in) begin
                  len_in   = 8'd0;
                  state_in = B_IDLE;
               end else begin
                  w_in     = w_ff + 5'd1;
                  state_in = B_RD;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         len_ff   <= 8'd0;
         start_ff <= '0;
         w_ff     <= 5'd0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         start_ff <= start_in;
         w_ff     <= w_in;
         out_v_ff <= out_v_in;
      end
      word_ff <= word_in;
      nb_ff   <= nb_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_report_word = word_ff;
   assign rsp_valid_bytes = nb_ff;
   assign rsp_report_last = last_ff;

   `FDP_ASSERT(a_len_bound, len_ff <= 8'(MAX_PAYLOAD), "payload length above limit")
   `FDP_ASSERT(a_no_pop_emit, state_ff != B_IDLE |-> !cmd_pop, "command taken during report")
   `FDP_ASSERT(a_drop_on_accept, $fell(out_v_ff) |-> $past(rsp_ready), "word dropped unaccepted")
   `FDP_ASSERT_ALWAYS(a_emit_nonempty, state_ff == B_WR |-> len_ff != 8'd0, "empty report sent")
endmodule

### src/frame_delta_packetizer.sv
// Frame delta packetizer: takes one frame byte per transfer, compares it with a shadow
// frame and sends changed runs as padded write reports in 64-bit words. After reset the
// shadow frame is cleared to 0x55, with req_ready low. Each byte then passes through a
// registered shadow read and then pushes its commands (up to 4 gap bytes and the byte,
// or a flush after a long clean run, plus a flush at frame end) into the four-entry
// command queue, stalling while it is full. A report leaves word by word from the payload
// buffer, up to 17 words; the front keeps working until the command queue fills.
`timescale 1ns / 1ps
module frame_delta_packetizer
   import fdp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_report_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_report_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [10:0] frame_size_ff;
   logic [7:0]  report_id_ff;
   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type     cmd_in, cmd_out;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_REPORT_ID) ? {24'd0, report_id_ff}
                                               : {21'd0, frame_size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= FRAME_SIZE_RESET;
         report_id_ff  <= REPORT_ID_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_FRAME_SIZE) begin
            frame_size_ff <= pwdata[10:0];
         end else begin
            report_id_ff <= pwdata[7:0];
         end
      end
   end

   fdp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_byte (req_pixel_byte),
      .frame_size     (frame_size_ff),
      .cmd_push       (cmd_push),
      .cmd_in         (cmd_in),
      .cmd_full       (cmd_full)
   );

   fdp_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .cmd_in  (cmd_in),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .cmd_out (cmd_out),
      .empty   (cmd_empty)
   );

   fdp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (cmd_empty),
      .cmd_out         (cmd_out),
      .cmd_pop         (cmd_pop),
      .report_id       (report_id_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_report_word (rsp_report_word),
      .rsp_valid_bytes (rsp_valid_bytes),
      .rsp_report_last (rsp_report_last)
   );
endmodule
